[rtl/rrfc_pkg.sv]
// package: shared types and constants of the reader reply frame classifier
package rrfc_pkg;

    // parse phases
    typedef enum logic [1:0] {
        PH_EMPTY  = 2'd0,
        PH_PRIMED = 2'd1,
        PH_FRAME  = 2'd2,
        PH_DONE   = 2'd3
    } phase_t;

    // result codes
    localparam logic [2:0] RC_NONE     = 3'd0;
    localparam logic [2:0] RC_ITEM_ONE = 3'd1;
    localparam logic [2:0] RC_ITEM_TWO = 3'd2;
    localparam logic [2:0] RC_UNKNOWN  = 3'd3;
    localparam logic [2:0] RC_ERROR    = 3'd4;

    // tag pair classes
    localparam logic [1:0] PAIR_NONE = 2'd0;
    localparam logic [1:0] PAIR_ONE  = 2'd1;
    localparam logic [1:0] PAIR_TWO  = 2'd2;

    // operations
    localparam logic OP_BYTE  = 1'b0;
    localparam logic OP_BURST = 1'b1;

    // register indexes
    localparam logic [1:0] REG_HEADER = 2'd0;
    localparam logic [1:0] REG_ITEM1  = 2'd1;
    localparam logic [1:0] REG_ITEM2  = 2'd2;
    localparam logic [1:0] REG_NOTAG  = 2'd3;

    // register reset values
    localparam logic [15:0] HEADER_RST = 16'h5246;
    localparam logic [15:0] ITEM1_RST  = 16'h0001;
    localparam logic [15:0] ITEM2_RST  = 16'h0002;
    localparam logic [23:0] NOTAG_RST  = 24'h070150;

    // frame bytes
    localparam logic [7:0]  TYPE_GOOD    = 8'h01;
    localparam logic [7:0]  CMD_PLAIN    = 8'h21;
    localparam logic [7:0]  CMD_TAG_READ = 8'h22;
    localparam logic [15:0] LEN_NO_TAG   = 16'd3;
    localparam logic [15:0] LEN_FIXED    = 16'd9;

    // frame positions
    localparam int unsigned POS_W = 17;
    localparam logic [POS_W-1:0] POS_HDR_END  = 17'd2;
    localparam logic [POS_W-1:0] POS_TYPE     = 17'd2;
    localparam logic [POS_W-1:0] POS_CMD      = 17'd5;
    localparam logic [POS_W-1:0] POS_LEN_HI   = 17'd6;
    localparam logic [POS_W-1:0] POS_LEN_LO   = 17'd7;
    localparam logic [POS_W-1:0] POS_PAYLOAD  = 17'd8;
    localparam logic [POS_W-1:0] POS_PAIR2    = 17'd9;
    localparam logic [POS_W-1:0] POS_NOTAG_B1 = 17'd9;
    localparam logic [POS_W-1:0] POS_NOTAG_B2 = 17'd10;
    localparam logic [POS_W-1:0] POS_FIXED    = 17'd16;
    localparam logic [POS_W-1:0] POS_MAX      = 17'h1FFFF;

    // one result transaction
    typedef struct packed {
        logic [2:0] result_code;
        logic [7:0] command_code;
    } result_t;

endpackage

[rtl/rrfc_in_if.sv]
// interface: input byte channel
interface rrfc_in_if;
    logic       valid;
    logic       ready;
    logic       operation;
    logic [7:0] data_byte;

    modport source (output valid, output operation, output data_byte, input ready);
    modport sink (input valid, input operation, input data_byte, output ready);
endinterface

[rtl/rrfc_out_if.sv]
// interface: result channel
interface rrfc_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] result_code;
    logic [7:0] command_code;

    modport source (output valid, output result_code, output command_code, input ready);
    modport sink (input valid, input result_code, input command_code, output ready);
endinterface

[rtl/reader_reply_frame_classifier_core.sv]
// top level: reader reply frame classifier
//
// Usage:
//   byte_in carries one transaction per reply byte (operation 0) or an end of
//   burst marker (operation 1). class_out carries one class per completed
//   frame, and one error for an end of burst that arrives before a frame is
//   complete. Registers are written through write_enable / write_index /
//   write_data while no transaction is in flight.
// Throughput and timing: one transaction is accepted every cycle while
//   byte_in.ready is high; a result is shown the cycle after the accepting
//   edge if none is waiting. The per-byte parse step is a single pass of
//   compare and count logic between the parse state and the result register.
// Stall:
//   a two-entry result buffer (output register plus skid register) sits in
//   front of class_out; byte_in.ready falls only while both entries hold
//   results, so bytes keep flowing while one result waits.
// Reset:
//   rst_n clears the parse state, empties the result buffer and loads the
//   register defaults; hunting for a header starts afresh.
module reader_reply_frame_classifier_core
    import rrfc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    rrfc_in_if.sink     byte_in,
    rrfc_out_if.source  class_out,
    input  logic        write_enable,
    input  logic [1:0]  write_index,
    input  logic [23:0] write_data
);

    // configuration registers
    logic [15:0] header_reg;
    logic [15:0] item1_reg;
    logic [15:0] item2_reg;
    logic [23:0] notag_reg;

    // parse state
    phase_t           phase_reg, phase_next;
    logic [7:0]       prev_reg, prev_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic             type_ok_reg, type_ok_next;
    logic [7:0]       cmd_reg, cmd_next;
    logic [15:0]      len_reg, len_next;
    logic             notag_ok_reg, notag_ok_next;
    logic [1:0]       first_reg, first_next;
    logic [1:0]       fixed_reg, fixed_next;
    logic [7:0]       pair_reg, pair_next;

    // result buffer
    result_t main_reg, skid_reg;
    logic    main_valid_reg, skid_valid_reg;

    logic    accept;
    logic    pop;
    logic    has_result;
    result_t res;
    logic [7:0] want_byte;

    function automatic logic [1:0] tag_class(input logic [7:0] hi, input logic [7:0] lo,
                                             input logic [15:0] t1, input logic [15:0] t2);
        logic [15:0] pair;
        pair = {hi, lo};
        if (pair == t1) return PAIR_ONE;
        if (pair == t2) return PAIR_TWO;
        return PAIR_NONE;
    endfunction

    function automatic logic [2:0] classify(input logic t_ok, input logic [7:0] cmd,
                                            input logic [15:0] len, input logic nt_ok,
                                            input logic [1:0] fixed, input logic [1:0] first);
        if (!t_ok) return RC_ERROR;
        if (cmd == CMD_PLAIN) return RC_NONE;
        if (cmd != CMD_TAG_READ) return RC_ERROR;
        if (len == LEN_NO_TAG) return nt_ok ? RC_NONE : RC_ERROR;
        if (len >= LEN_FIXED && fixed != PAIR_NONE) return {1'b0, fixed};
        if (first != PAIR_NONE) return {1'b0, first};
        return RC_UNKNOWN;
    endfunction

    assign byte_in.ready = !skid_valid_reg;
    assign accept        = byte_in.valid && !skid_valid_reg;
    assign pop           = main_valid_reg && class_out.ready;

    assign class_out.valid        = main_valid_reg;
    assign class_out.result_code  = main_reg.result_code;
    assign class_out.command_code = main_reg.command_code;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_reg <= HEADER_RST;
            item1_reg  <= ITEM1_RST;
            item2_reg  <= ITEM2_RST;
            notag_reg  <= NOTAG_RST;
        end
        else if (write_enable)
        begin
            case (write_index)
                REG_HEADER: header_reg <= write_data[15:0];
                REG_ITEM1:  item1_reg  <= write_data[15:0];
                REG_ITEM2:  item2_reg  <= write_data[15:0];
                REG_NOTAG:  notag_reg  <= write_data;
                default:    header_reg <= header_reg;
            endcase
        end
    end

    // expected no-tag byte at the current payload position
    always_comb
    begin
        case (pos_reg)
            POS_PAYLOAD:  want_byte = notag_reg[23:16];
            POS_NOTAG_B1: want_byte = notag_reg[15:8];
            default:      want_byte = notag_reg[7:0];
        endcase
    end

    // parse step for one accepted transaction
    always_comb
    begin
        phase_next    = phase_reg;
        prev_next     = prev_reg;
        pos_next      = pos_reg;
        type_ok_next  = type_ok_reg;
        cmd_next      = cmd_reg;
        len_next      = len_reg;
        notag_ok_next = notag_ok_reg;
        first_next    = first_reg;
        fixed_next    = fixed_reg;
        pair_next     = pair_reg;
        has_result    = 1'b0;
        res           = '{result_code: RC_ERROR, command_code: cmd_reg};

        if (accept)
        begin
            if (byte_in.operation == OP_BURST)
            begin
                // end of burst: error unless a frame completed
                has_result    = (phase_reg != PH_DONE);
                phase_next    = PH_EMPTY;
                prev_next     = 8'd0;
                pos_next      = '0;
                type_ok_next  = 1'b0;
                cmd_next      = 8'd0;
                len_next      = 16'd0;
                notag_ok_next = 1'b1;
                first_next    = PAIR_NONE;
                fixed_next    = PAIR_NONE;
                pair_next     = 8'd0;
            end
            else if (phase_reg == PH_DONE)
            begin
                prev_next = byte_in.data_byte;
            end
            else if (phase_reg != PH_FRAME)
            begin
                // header hunt
                if (phase_reg == PH_PRIMED && prev_reg == header_reg[15:8]
                    && byte_in.data_byte == header_reg[7:0])
                begin
                    phase_next    = PH_FRAME;
                    pos_next      = POS_HDR_END;
                    type_ok_next  = 1'b0;
                    cmd_next      = 8'd0;
                    len_next      = 16'd0;
                    notag_ok_next = 1'b1;
                    first_next    = PAIR_NONE;
                    fixed_next    = PAIR_NONE;
                    pair_next     = 8'd0;
                end
                else
                begin
                    phase_next = PH_PRIMED;
                end
                prev_next = byte_in.data_byte;
            end
            else
            begin
                // frame body
                if (pos_reg == POS_TYPE)
                    type_ok_next = (byte_in.data_byte == TYPE_GOOD);
                else if (pos_reg == POS_CMD)
                    cmd_next = byte_in.data_byte;
                else if (pos_reg == POS_LEN_HI)
                    len_next = {byte_in.data_byte, len_reg[7:0]};
                else if (pos_reg == POS_LEN_LO)
                    len_next = {len_reg[15:8], byte_in.data_byte};
                else if (pos_reg >= POS_PAYLOAD)
                begin
                    if (pos_reg <= POS_NOTAG_B2 && byte_in.data_byte != want_byte)
                        notag_ok_next = 1'b0;
                    if (pos_reg >= POS_PAIR2 && first_reg == PAIR_NONE)
                        first_next = tag_class(pair_reg, byte_in.data_byte,
                                               item1_reg, item2_reg);
                    if (pos_reg == POS_FIXED)
                        fixed_next = tag_class(pair_reg, byte_in.data_byte,
                                               item1_reg, item2_reg);
                    pair_next = byte_in.data_byte;
                end
                if (pos_reg != POS_MAX)
                    pos_next = pos_reg + 17'd1;
                prev_next = byte_in.data_byte;

                // frame completion
                if (pos_next >= POS_PAYLOAD && pos_next == ({1'b0, len_next} + POS_PAYLOAD))
                begin
                    has_result = 1'b1;
                    phase_next = PH_DONE;
                    res = '{result_code: classify(type_ok_next, cmd_next, len_next,
                                                  notag_ok_next, fixed_next, first_next),
                            command_code: cmd_next};
                end
            end
        end
    end

    // parse state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_EMPTY;
            prev_reg     <= 8'd0;
            pos_reg      <= '0;
            type_ok_reg  <= 1'b0;
            cmd_reg      <= 8'd0;
            len_reg      <= 16'd0;
            notag_ok_reg <= 1'b1;
            first_reg    <= PAIR_NONE;
            fixed_reg    <= PAIR_NONE;
            pair_reg     <= 8'd0;
        end
        else
        begin
            phase_reg    <= phase_next;
            prev_reg     <= prev_next;
            pos_reg      <= pos_next;
            type_ok_reg  <= type_ok_next;
            cmd_reg      <= cmd_next;
            len_reg      <= len_next;
            notag_ok_reg <= notag_ok_next;
            first_reg    <= first_next;
            fixed_reg    <= fixed_next;
            pair_reg     <= pair_next;
        end
    end

    // result buffer control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            if (skid_valid_reg)
            begin
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                main_valid_reg <= has_result;
            end
        end
        else if (!main_valid_reg)
        begin
            main_valid_reg <= has_result;
        end
        else if (has_result)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    // result buffer payload
    always_ff @(posedge clk)
    begin
        if (pop && skid_valid_reg)
            main_reg <= skid_reg;
        else if ((pop || !main_valid_reg) && has_result)
            main_reg <= res;
        else if (main_valid_reg && !pop && has_result)
            skid_reg <= res;
    end

endmodule

[rtl/rrfc_checker.sv]
// checker: port-level assertions for the frame classifier, with its bind
module rrfc_checker
    import rrfc_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [2:0] out_code,
    input logic [7:0] out_cmd
);

    // a shown result stays until taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    // input back-pressure only while the output holds a result
    a_ready_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("input stalled with empty output");

    // codes above error never appear
    a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_code <= RC_ERROR))
        else $error("result code out of range");

    // a none class only comes from the two known commands
    a_none_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_code == RC_NONE |->
            (out_cmd == CMD_PLAIN || out_cmd == CMD_TAG_READ))
        else $error("none class with unexpected command");

    // tag and unknown classes only come from a tag read
    a_tag_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_code == RC_ITEM_ONE || out_code == RC_ITEM_TWO
                      || out_code == RC_UNKNOWN) |-> out_cmd == CMD_TAG_READ)
        else $error("tag class with unexpected command");

endmodule

bind reader_reply_frame_classifier_core rrfc_checker u_rrfc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (byte_in.ready),
    .out_valid (class_out.valid),
    .out_ready (class_out.ready),
    .out_code  (class_out.result_code),
    .out_cmd   (class_out.command_code)
);
